FILE: rtl/core/pcdw_pkg.sv
// ----------------------------------------------------------------------------
// pcdw_pkg
// Shared widths, step tables and types for the prism current deposit unit.
// ----------------------------------------------------------------------------
package pcdw_pkg;

   // fixed point fraction bits of charge, coordinates and results
   localparam int FRAC_BITS = 16;

   // port widths
   localparam int COORD_W  = 18;
   localparam int CHARGE_W = 32;
   localparam int INC_W    = 32;

   // datapath widths
   localparam int OPW  = COORD_W + 1;                 // multiplier operands
   localparam int PW   = 2 * OPW;                     // operand products
   localparam int ARW  = PW + 2 - FRAC_BITS;          // rounded area term
   localparam int SW   = (FRAC_BITS + 3 > 20) ? FRAC_BITS + 3 : 20;  // hat sums
   localparam int WPW  = ARW + SW;                    // area times hat sum
   localparam int WW   = ARW + SW - FRAC_BITS + 1;    // edge weight, negatable
   localparam int CPW  = CHARGE_W + WW;               // charge times weight
   localparam int STEP_W = 4;                          // result step counter

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(8);

   // edge groups
   localparam logic [1:0] GRP_BOTTOM = 2'd0;
   localparam logic [1:0] GRP_TOP    = 2'd1;
   localparam logic [1:0] GRP_VERT   = 2'd2;

   // register map (word index)
   localparam logic REG_CHARGE = 1'b0;

   // triangle edge j runs from vertex TRI_FROM[j] to vertex TRI_TO[j]
   localparam logic [1:0] TRI_FROM [3] = '{2'd0, 2'd1, 2'd2};
   localparam logic [1:0] TRI_TO   [3] = '{2'd1, 2'd2, 2'd0};

   // per-result tag carried down the pipe
   typedef struct packed {
      logic       valid;
      logic [1:0] group;
      logic [1:0] index;
      logic       neg;
      logic       last;
   } tag_type;

   // edge group of each of the nine result steps
   function automatic logic [1:0] step_group(input logic [STEP_W-1:0] step);
      logic [1:0] g;
      case (step)
         4'd0, 4'd2, 4'd4: g = GRP_BOTTOM;
         4'd1, 4'd3, 4'd5: g = GRP_TOP;
         default:          g = GRP_VERT;
      endcase
      return g;
   endfunction

   // local edge or vertex index of each result step
   function automatic logic [1:0] step_index(input logic [STEP_W-1:0] step);
      logic [1:0] i;
      case (step)
         4'd0, 4'd1, 4'd6: i = 2'd0;
         4'd2, 4'd3, 4'd7: i = 2'd1;
         default:          i = 2'd2;
      endcase
      return i;
   endfunction

endpackage

FILE: rtl/core/prism_current_deposit_weights_unit.sv
// ----------------------------------------------------------------------------
// prism_current_deposit_weights_unit
// Whitney-form current increments for one particle move inside a prism:
// nine results per move, one per prism edge, saturated signed fixed point.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  request   start / busy         req_old_*, req_new_*, req_edge_signs
//  response  rsp_valid (strobe)   rsp_edge_group, rsp_local_index,
//                                 rsp_increment, rsp_last
//  csr       psel/penable/pwrite  paddr, pwdata, prdata, pready
//
// a move produces nine results on consecutive cycles, the first one once
// the move has passed the sequencer and the seven stage arithmetic pipe;
// the result sequencer issues one step per cycle into that pipe, so moves
// can follow back to back (busy drops while the ninth step issues).
// reset clears the sequencer and pipe valids and sets charge_over_dt to one.
// results cannot be held off, so the pipe never stalls.
//
module prism_current_deposit_weights_unit
   import pcdw_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // request
   input  logic                       start,
   output logic                       busy,
   input  logic signed [COORD_W-1:0]  req_old_l0,
   input  logic signed [COORD_W-1:0]  req_old_l1,
   input  logic signed [COORD_W-1:0]  req_old_l2,
   input  logic signed [COORD_W-1:0]  req_old_zeta,
   input  logic signed [COORD_W-1:0]  req_new_l0,
   input  logic signed [COORD_W-1:0]  req_new_l1,
   input  logic signed [COORD_W-1:0]  req_new_l2,
   input  logic signed [COORD_W-1:0]  req_new_zeta,
   input  logic [2:0]                 req_edge_signs,
   // response
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_edge_group,
   output logic [1:0]                 rsp_local_index,
   output logic signed [INC_W-1:0]    rsp_increment,
   output logic                       rsp_last,
   // csr
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [2:0]                 paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   localparam logic signed [CHARGE_W-1:0] CHARGE_RESET = CHARGE_W'(1) << FRAC_BITS;
   localparam logic signed [SW-1:0]       TWO_ONE      = SW'(1) << (FRAC_BITS + 1);
   localparam logic signed [PW+1:0]       HALF_A       = (PW + 2)'(1) << (FRAC_BITS - 1);
   localparam logic signed [PW:0]         HALF_V       = (PW + 1)'(1) << FRAC_BITS;
   localparam logic signed [WPW:0]        HALF_W       = (WPW + 1)'(1) << FRAC_BITS;
   localparam logic signed [CPW:0]        HALF_C       = (CPW + 1)'(1) << (FRAC_BITS - 1);

   // ---------------------------------------------------------------- csr
   logic signed [CHARGE_W-1:0] charge_ff;
   logic                       csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[2] == REG_CHARGE);
   assign prdata = (paddr[2] == REG_CHARGE) ? charge_ff : '0;

   // charge over time step register
   always_ff @(posedge clock) begin
      if (reset) begin
         charge_ff <= CHARGE_RESET;
      end else if (csr_wr) begin
         charge_ff <= pwdata;
      end
   end

   // ---------------------------------------------------------------- move register and sequencer
   logic signed [COORD_W-1:0] lo_ff [3];
   logic signed [COORD_W-1:0] ln_ff [3];
   logic signed [COORD_W-1:0] zo_ff;
   logic signed [COORD_W-1:0] zn_ff;
   logic [2:0]                signs_ff;
   logic                      active_ff, active_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic                      take;

   assign busy = active_ff && (step_ff != LAST_STEP);
   assign take = start && !busy;

   // next sequencer state
   always_comb begin
      active_in = active_ff;
      step_in   = step_ff;
      if (take) begin
         active_in = 1'b1;
         step_in   = '0;
      end else if (active_ff) begin
         if (step_ff == LAST_STEP) begin
            active_in = 1'b0;
         end else begin
            step_in = step_ff + STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         step_ff   <= '0;
      end else begin
         active_ff <= active_in;
         step_ff   <= step_in;
      end
   end

   // move payload, held for the nine steps
   always_ff @(posedge clock) begin
      if (take) begin
         lo_ff[0] <= req_old_l0;
         lo_ff[1] <= req_old_l1;
         lo_ff[2] <= req_old_l2;
         ln_ff[0] <= req_new_l0;
         ln_ff[1] <= req_new_l1;
         ln_ff[2] <= req_new_l2;
         zo_ff    <= req_old_zeta;
         zn_ff    <= req_new_zeta;
         signs_ff <= req_edge_signs;
      end
   end

   // ---------------------------------------------------------------- stage 1: operand select
   logic [1:0]            sel_grp, sel_idx, sel_from, sel_to;
   logic                  sel_vert;
   logic signed [OPW-1:0] lo_f, lo_t, dl_f, dl_t, l_sum, dz;
   logic signed [SW-1:0]  z_sum;
   tag_type               tag_in;

   logic signed [OPW-1:0] m1a_ff, m1b_ff, m2a_ff, m2b_ff;
   logic signed [SW-1:0]  s1_hat_ff;
   tag_type               tag1_ff;

   always_comb begin
      sel_grp  = step_group(step_ff);
      sel_idx  = step_index(step_ff);
      sel_vert = (sel_grp == GRP_VERT);
      sel_from = TRI_FROM[sel_idx];
      sel_to   = TRI_TO[sel_idx];
      lo_f     = OPW'(lo_ff[sel_from]);
      lo_t     = OPW'(lo_ff[sel_to]);
      dl_f     = OPW'(ln_ff[sel_from]) - OPW'(lo_ff[sel_from]);
      dl_t     = OPW'(ln_ff[sel_to]) - OPW'(lo_ff[sel_to]);
      l_sum    = OPW'(lo_ff[sel_idx]) + OPW'(ln_ff[sel_idx]);
      dz       = OPW'(zn_ff) - OPW'(zo_ff);
      z_sum    = SW'(zo_ff) + SW'(zn_ff);
      tag_in.valid = active_ff;
      tag_in.group = sel_grp;
      tag_in.index = sel_idx;
      tag_in.neg   = !sel_vert && signs_ff[sel_idx];
      tag_in.last  = (step_ff == LAST_STEP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid <= 1'b0;
      end else begin
         tag1_ff.valid <= tag_in.valid;
      end
      tag1_ff.group <= tag_in.group;
      tag1_ff.index <= tag_in.index;
      tag1_ff.neg   <= tag_in.neg;
      tag1_ff.last  <= tag_in.last;
      m1a_ff    <= sel_vert ? l_sum : lo_f;
      m1b_ff    <= sel_vert ? dz : dl_t;
      m2a_ff    <= sel_vert ? '0 : lo_t;
      m2b_ff    <= sel_vert ? '0 : dl_f;
      s1_hat_ff <= (sel_grp == GRP_TOP) ? z_sum : TWO_ONE - z_sum;
   end

   // ---------------------------------------------------------------- stage 2: operand products
   logic signed [PW-1:0] p1_ff, p2_ff;
   logic signed [SW-1:0] s2_hat_ff;
   tag_type              tag2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag2_ff.valid <= 1'b0;
      end else begin
         tag2_ff.valid <= tag1_ff.valid;
      end
      tag2_ff.group <= tag1_ff.group;
      tag2_ff.index <= tag1_ff.index;
      tag2_ff.neg   <= tag1_ff.neg;
      tag2_ff.last  <= tag1_ff.last;
      p1_ff     <= m1a_ff * m1b_ff;
      p2_ff     <= m2a_ff * m2b_ff;
      s2_hat_ff <= s1_hat_ff;
   end

   // ---------------------------------------------------------------- stage 3: area term and vertical weight rounding
   logic signed [PW+1:0] area_rnd;
   logic signed [PW:0]   vert_rnd;
   logic signed [ARW-1:0] ar_ff;
   logic signed [WW-1:0]  v3_ff;
   logic signed [SW-1:0]  s3_hat_ff;
   tag_type               tag3_ff;

   always_comb begin
      area_rnd = ((PW + 2)'(p1_ff) - (PW + 2)'(p2_ff) + HALF_A) >>> FRAC_BITS;
      vert_rnd = ((PW + 1)'(p1_ff) + HALF_V) >>> (FRAC_BITS + 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag3_ff.valid <= 1'b0;
      end else begin
         tag3_ff.valid <= tag2_ff.valid;
      end
      tag3_ff.group <= tag2_ff.group;
      tag3_ff.index <= tag2_ff.index;
      tag3_ff.neg   <= tag2_ff.neg;
      tag3_ff.last  <= tag2_ff.last;
      ar_ff     <= ARW'(area_rnd);
      v3_ff     <= WW'(vert_rnd);
      s3_hat_ff <= s2_hat_ff;
   end

   // ---------------------------------------------------------------- stage 4: area times average hat
   logic signed [WPW-1:0] wprod_ff;
   logic signed [WW-1:0]  v4_ff;
   tag_type               tag4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag4_ff.valid <= 1'b0;
      end else begin
         tag4_ff.valid <= tag3_ff.valid;
      end
      tag4_ff.group <= tag3_ff.group;
      tag4_ff.index <= tag3_ff.index;
      tag4_ff.neg   <= tag3_ff.neg;
      tag4_ff.last  <= tag3_ff.last;
      wprod_ff <= WPW'(ar_ff) * WPW'(s3_hat_ff);
      v4_ff    <= v3_ff;
   end

   // ---------------------------------------------------------------- stage 5: weight rounding, edge sign
   logic signed [WPW:0]  w_rnd;
   logic signed [WW-1:0] w_hor, w_sel;
   logic signed [WW-1:0] w_ff;
   tag_type              tag5_ff;

   always_comb begin
      w_rnd = ((WPW + 1)'(wprod_ff) + HALF_W) >>> (FRAC_BITS + 1);
      w_hor = WW'(w_rnd);
      if (tag4_ff.group == GRP_VERT) begin
         w_sel = v4_ff;
      end else if (tag4_ff.neg) begin
         w_sel = -w_hor;
      end else begin
         w_sel = w_hor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag5_ff.valid <= 1'b0;
      end else begin
         tag5_ff.valid <= tag4_ff.valid;
      end
      tag5_ff.group <= tag4_ff.group;
      tag5_ff.index <= tag4_ff.index;
      tag5_ff.neg   <= tag4_ff.neg;
      tag5_ff.last  <= tag4_ff.last;
      w_ff <= w_sel;
   end

   // ---------------------------------------------------------------- stage 6: charge scaling
   logic signed [CPW-1:0] cprod_ff;
   tag_type               tag6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag6_ff.valid <= 1'b0;
      end else begin
         tag6_ff.valid <= tag5_ff.valid;
      end
      tag6_ff.group <= tag5_ff.group;
      tag6_ff.index <= tag5_ff.index;
      tag6_ff.neg   <= tag5_ff.neg;
      tag6_ff.last  <= tag5_ff.last;
      cprod_ff <= CPW'(charge_ff) * CPW'(w_ff);
   end

   // ---------------------------------------------------------------- stage 7: round, saturate, result register
   logic signed [CPW:0]    c_rnd;
   logic signed [INC_W-1:0] inc_sat;
   logic                    fits;

   always_comb begin
      c_rnd = ((CPW + 1)'(cprod_ff) + HALF_C) >>> FRAC_BITS;
      fits  = (&c_rnd[CPW:INC_W-1]) || !(|c_rnd[CPW:INC_W-1]);
      if (fits) begin
         inc_sat = c_rnd[INC_W-1:0];
      end else if (c_rnd[CPW]) begin
         inc_sat = {1'b1, {(INC_W - 1){1'b0}}};
      end else begin
         inc_sat = {1'b0, {(INC_W - 1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= tag6_ff.valid;
      end
      rsp_edge_group  <= tag6_ff.group;
      rsp_local_index <= tag6_ff.index;
      rsp_last        <= tag6_ff.last;
      rsp_increment   <= inc_sat;
   end

   // ---------------------------------------------------------------- assertions
   // first beat of a move after start is taken is bottom edge 0, not flagged last
   a_first_beat: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##8 (rsp_valid && rsp_edge_group == GRP_BOTTOM
                                && rsp_local_index == 2'd0 && !rsp_last))
      else $error("first result beat of a move missing or misplaced");

   // ninth beat closes the move
   a_last_beat: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##16 (rsp_valid && rsp_last))
      else $error("last result beat of a move missing");

   // last only on the third vertical edge
   a_last_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_edge_group == GRP_VERT && rsp_local_index == 2'd2))
      else $error("last flag on the wrong edge slot");

   // sequencer never lets a new move in before the current one issued its ninth step
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (active_ff && step_ff != LAST_STEP) |-> busy)
      else $error("move accepted while steps remain");

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the prism current deposit unit. Moves go in on the
// start/busy command port; an in-bench fixed point predictor works out the
// nine saturated edge increments of each move, and every strobed result beat
// is checked field by field in order. Over the csr port the charge register
// is read back at reset and set between phases to extremes and random values.
// ----------------------------------------------------------------------------
module testbench
   import pcdw_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [COORD_W-1:0] coord_type;

   // one particle move as presented on the request port
   typedef struct {
      coord_type  old_l [3];
      coord_type  old_z;
      coord_type  new_l [3];
      coord_type  new_z;
      logic [2:0] signs;
   } move_type;

   // one expected result beat
   typedef struct packed {
      logic [1:0]              group;
      logic [1:0]              index;
      logic signed [INC_W-1:0] increment;
      logic                    last;
   } increment_type;

   // csr byte addresses
   localparam logic [2:0] ADDR_CHARGE   = {REG_CHARGE, 2'b00};
   localparam logic [2:0] ADDR_UNMAPPED = 3'd4;

   localparam int ONE_Q = 1 << FRAC_BITS;
   localparam int DRAIN_CYCLES = 12;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   coord_type req_old_l0, req_old_l1, req_old_l2, req_old_zeta;
   coord_type req_new_l0, req_new_l1, req_new_l2, req_new_zeta;
   logic [2:0] req_edge_signs;
   logic rsp_valid;
   logic [1:0] rsp_edge_group;
   logic [1:0] rsp_local_index;
   logic signed [INC_W-1:0] rsp_increment;
   logic rsp_last;
   logic psel, penable, pwrite, pready;
   logic [2:0] paddr;
   logic [31:0] pwdata, prdata;

   // predictor copy of the charge register
   longint charge_q;
   // increments still owed by the block, oldest first
   increment_type pending_increments [$];
   int mismatches;

   prism_current_deposit_weights_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_old_l0      (req_old_l0),
      .req_old_l1      (req_old_l1),
      .req_old_l2      (req_old_l2),
      .req_old_zeta    (req_old_zeta),
      .req_new_l0      (req_new_l0),
      .req_new_l1      (req_new_l1),
      .req_new_l2      (req_new_l2),
      .req_new_zeta    (req_new_zeta),
      .req_edge_signs  (req_edge_signs),
      .rsp_valid       (rsp_valid),
      .rsp_edge_group  (rsp_edge_group),
      .rsp_local_index (rsp_local_index),
      .rsp_increment   (rsp_increment),
      .rsp_last        (rsp_last),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // shift right by k, rounding half toward plus infinity
   function automatic longint round_shift(longint x, int k);
      return (x + (longint'(1) <<< (k - 1))) >>> k;
   endfunction

   function automatic logic signed [INC_W-1:0] sat_inc(longint x);
      if (x > longint'(32'sh7fffffff)) return 32'sh7fffffff;
      if (x < -longint'(64'h80000000)) return 32'sh80000000;
      return x[INC_W-1:0];
   endfunction

   // nine expected increments of one move, in output order
   function automatic void predict_deposit(move_type m);
      longint lo [3], ln [3], dl [3];
      longint zo, zn, dz, s0, s1, a, ar, wb, wt, v;
      int t;
      for (int i = 0; i < 3; i++) begin
         lo[i] = m.old_l[i];
         ln[i] = m.new_l[i];
         dl[i] = ln[i] - lo[i];
      end
      zo = m.old_z;
      zn = m.new_z;
      dz = zn - zo;
      s0 = 2 * ONE_Q - zo - zn;
      s1 = zo + zn;
      // horizontal edges: bottom then top for each triangle edge
      for (int j = 0; j < 3; j++) begin
         t  = (j + 1) % 3;
         a  = lo[j] * dl[t] - lo[t] * dl[j];
         ar = round_shift(a, FRAC_BITS);
         wb = round_shift(ar * s0, FRAC_BITS + 1);
         wt = round_shift(ar * s1, FRAC_BITS + 1);
         if (m.signs[j]) begin
            wb = -wb;
            wt = -wt;
         end
         pending_increments.push_back(
            '{GRP_BOTTOM, 2'(j), sat_inc(round_shift(charge_q * wb, FRAC_BITS)), 1'b0});
         pending_increments.push_back(
            '{GRP_TOP, 2'(j), sat_inc(round_shift(charge_q * wt, FRAC_BITS)), 1'b0});
      end
      // vertical edges at each vertex
      for (int i = 0; i < 3; i++) begin
         v = round_shift(dz * (lo[i] + ln[i]), FRAC_BITS + 1);
         pending_increments.push_back(
            '{GRP_VERT, 2'(i), sat_inc(round_shift(charge_q * v, FRAC_BITS)), i == 2});
      end
   endfunction

   function automatic void check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %s: expected %0d, got %0d", name, exp_v, act_v);
      end
   endfunction

   // result beat checker
   always @(posedge clock) begin
      increment_type exp_r;
      if (!reset && rsp_valid) begin
         if (pending_increments.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: group %0d index %0d increment %0d",
                        rsp_edge_group, rsp_local_index, rsp_increment);
         end else begin
            exp_r = pending_increments.pop_front();
            check_field("edge_group", exp_r.group, rsp_edge_group);
            check_field("local_index", exp_r.index, rsp_local_index);
            check_field("increment", exp_r.increment, rsp_increment);
            check_field("last", exp_r.last, rsp_last);
         end
      end
   end

   // present one move and hold it until the block takes it
   task automatic send_move(move_type m);
      @(negedge clock);
      req_old_l0     = m.old_l[0];
      req_old_l1     = m.old_l[1];
      req_old_l2     = m.old_l[2];
      req_old_zeta   = m.old_z;
      req_new_l0     = m.new_l[0];
      req_new_l1     = m.new_l[1];
      req_new_l2     = m.new_l[2];
      req_new_zeta   = m.new_z;
      req_edge_signs = m.signs;
      start          = 1'b1;
      do @(posedge clock); while (busy);
      predict_deposit(m);
   endtask

   // sender idles for a random number of cycles
   task automatic sender_gap(int pct);
      while ($urandom_range(0, 99) < pct) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   // stop sending and let every owed result come out
   task automatic wait_drained();
      @(negedge clock);
      start = 1'b0;
      while (pending_increments.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = addr;
      pwdata  = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      // only the charge register exists, other indexes are dropped
      if (addr == ADDR_CHARGE) charge_q = longint'(signed'(data));
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   // read back the charge register and compare with the predictor copy
   task automatic csr_check_charge();
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = ADDR_CHARGE;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      check_field("charge_over_dt readback", charge_q[31:0], prdata);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   function automatic coord_type pick_extreme();
      case ($urandom_range(0, 4))
         0:       return coord_type'(-131072);
         1:       return coord_type'(131071);
         2:       return coord_type'(0);
         3:       return coord_type'(ONE_Q);
         default: return coord_type'(-1);
      endcase
   endfunction

   // random point inside the cell: barycentrics summing to one, zeta in [0,1]
   function automatic void cell_point(output coord_type l0, output coord_type l1,
                                      output coord_type l2, output coord_type z);
      int a, b;
      a  = $urandom_range(0, ONE_Q);
      b  = $urandom_range(0, ONE_Q - a);
      l0 = coord_type'(a);
      l1 = coord_type'(b);
      l2 = coord_type'(ONE_Q - a - b);
      z  = coord_type'($urandom_range(0, ONE_Q));
   endfunction

   function automatic move_type random_move();
      move_type m;
      int mode;
      mode = $urandom_range(0, 9);
      cell_point(m.old_l[0], m.old_l[1], m.old_l[2], m.old_z);
      cell_point(m.new_l[0], m.new_l[1], m.new_l[2], m.new_z);
      m.signs = 3'($urandom_range(0, 7));
      case (mode)
         // short step from inside the cell, may leave it
         4, 5, 6: begin
            for (int i = 0; i < 3; i++)
               m.new_l[i] = m.old_l[i] + coord_type'($urandom_range(0, 4096) - 2048);
            m.new_z = m.old_z + coord_type'($urandom_range(0, 4096) - 2048);
         end
         // raw noise over the full field range
         7: begin
            for (int i = 0; i < 3; i++) begin
               m.old_l[i] = coord_type'($urandom);
               m.new_l[i] = coord_type'($urandom);
            end
            m.old_z = coord_type'($urandom);
            m.new_z = coord_type'($urandom);
         end
         8: begin
            for (int i = 0; i < 3; i++) begin
               m.old_l[i] = pick_extreme();
               m.new_l[i] = pick_extreme();
            end
            m.old_z = pick_extreme();
            m.new_z = pick_extreme();
         end
         // particle at rest
         9: begin
            m.new_l = m.old_l;
            m.new_z = m.old_z;
         end
         default: ;
      endcase
      return m;
   endfunction

   function automatic move_type corner_move(int which);
      move_type m;
      coord_type lo_v, hi_v;
      lo_v = coord_type'(-131072);
      hi_v = coord_type'(131071);
      m.old_l = '{coord_type'(0), coord_type'(0), coord_type'(0)};
      m.new_l = m.old_l;
      m.old_z = '0;
      m.new_z = '0;
      m.signs = 3'd0;
      case (which)
         1: begin
            m.old_l = '{hi_v, hi_v, hi_v};
            m.old_z = hi_v;
            m.new_l = '{lo_v, lo_v, lo_v};
            m.new_z = lo_v;
         end
         2: begin
            m.old_l = '{lo_v, lo_v, lo_v};
            m.old_z = lo_v;
            m.new_l = '{hi_v, hi_v, hi_v};
            m.new_z = hi_v;
            m.signs = 3'd7;
         end
         // vertex to vertex, bottom to top of the layer
         3: begin
            m.old_l = '{coord_type'(ONE_Q), coord_type'(0), coord_type'(0)};
            m.new_l = '{coord_type'(0), coord_type'(ONE_Q), coord_type'(0)};
            m.new_z = coord_type'(ONE_Q);
         end
         // far outside the cell, alternating extremes
         4: begin
            m.old_l = '{hi_v, lo_v, hi_v};
            m.old_z = lo_v;
            m.new_l = '{lo_v, hi_v, lo_v};
            m.new_z = hi_v;
            m.signs = 3'd5;
         end
         default: ;
      endcase
      return m;
   endfunction

   // reset value of the charge register
   task automatic test_charge_reset_value();
      csr_check_charge();
   endtask

   // every combination of triangle edge signs on one ordinary move
   task automatic test_edge_signs();
      move_type m;
      m.old_l = '{coord_type'(32768), coord_type'(16384), coord_type'(16384)};
      m.old_z = coord_type'(16384);
      m.new_l = '{coord_type'(13107), coord_type'(19661), coord_type'(32768)};
      m.new_z = coord_type'(49152);
      for (int s = 0; s < 8; s++) begin
         m.signs = 3'(s);
         send_move(m);
      end
      wait_drained();
   endtask

   // coordinate extremes under unit, largest and most negative charge
   task automatic test_extreme_moves();
      logic [31:0] charges [3];
      charges = '{32'(ONE_Q), 32'h7fffffff, 32'h80000000};
      for (int c = 0; c < 3; c++) begin
         if (c != 0) begin
            csr_write(ADDR_CHARGE, charges[c]);
            csr_check_charge();
         end
         for (int w = 0; w < 5; w++) send_move(corner_move(w));
         wait_drained();
      end
   endtask

   // a write to an unmapped index leaves the charge untouched
   task automatic test_unmapped_write();
      csr_write(ADDR_CHARGE, 32'h0003_8000);
      csr_write(ADDR_UNMAPPED, 32'hdead_beef);
      csr_check_charge();
      send_move(corner_move(3));
      wait_drained();
   endtask

   // random moves in four charge segments at one sender idle rate
   task automatic test_random_moves(int idle_pct, int n_moves);
      logic [31:0] charge;
      for (int seg = 0; seg < 4; seg++) begin
         case ($urandom_range(0, 5))
            0:       charge = $urandom;
            1:       charge = 32'($urandom_range(0, 1 << 19) - (1 << 18));
            2:       charge = 32'(ONE_Q * $urandom_range(1, 64));
            3:       charge = 32'(-ONE_Q);
            4:       charge = 32'd0;
            default: charge = 32'd1;
         endcase
         csr_write(ADDR_CHARGE, charge);
         for (int n = 0; n < n_moves / 4; n++) begin
            sender_gap(idle_pct);
            send_move(random_move());
         end
         wait_drained();
      end
   endtask

   // main sequence
   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_old_l0     = '0;
      req_old_l1     = '0;
      req_old_l2     = '0;
      req_old_zeta   = '0;
      req_new_l0     = '0;
      req_new_l1     = '0;
      req_new_l2     = '0;
      req_new_zeta   = '0;
      req_edge_signs = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      charge_q       = ONE_Q;
      mismatches     = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      repeat (DRAIN_CYCLES) @(posedge clock);

      test_charge_reset_value();
      test_edge_signs();
      test_extreme_moves();
      test_unmapped_write();
      test_random_moves(27, 140);
      test_random_moves(77, 140);
      test_random_moves(0, 140);

      wait_drained();
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
